// File: src/cursor_doubly_linked_list_defines.svh
// Assertion macros for the cursor linked list block.
// Needs clk and rst_n in the scope where they are used.
`ifndef CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH
`define CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH

// check a property at every clock edge out of reset
`define CDLL_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that cond is followed by resp in the next cycle
`define CDLL_CHECK_NEXT(lbl, cond, resp, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (resp)) else $error(msg);

`endif

// File: src/cdll_pkg.sv
// Shared constants for the cursor linked list block: field widths and command codes.
// No dependencies.
package cdll_pkg;

    localparam int MODE_W = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;

    localparam logic [MODE_W-1:0] M_CLEAR      = 5'd0;
    localparam logic [MODE_W-1:0] M_INS_FIRST  = 5'd1;
    localparam logic [MODE_W-1:0] M_INS_LAST   = 5'd2;
    localparam logic [MODE_W-1:0] M_FIRST      = 5'd3;
    localparam logic [MODE_W-1:0] M_LAST       = 5'd4;
    localparam logic [MODE_W-1:0] M_GET_FIRST  = 5'd5;
    localparam logic [MODE_W-1:0] M_GET_LAST   = 5'd6;
    localparam logic [MODE_W-1:0] M_DEL_FIRST  = 5'd7;
    localparam logic [MODE_W-1:0] M_DEL_LAST   = 5'd8;
    localparam logic [MODE_W-1:0] M_DEL_AFTER  = 5'd9;
    localparam logic [MODE_W-1:0] M_DEL_BEFORE = 5'd10;
    localparam logic [MODE_W-1:0] M_INS_AFTER  = 5'd11;
    localparam logic [MODE_W-1:0] M_INS_BEFORE = 5'd12;
    localparam logic [MODE_W-1:0] M_GET        = 5'd13;
    localparam logic [MODE_W-1:0] M_SET        = 5'd14;
    localparam logic [MODE_W-1:0] M_NEXT       = 5'd15;
    localparam logic [MODE_W-1:0] M_PREV       = 5'd16;

endpackage

// File: src/cursor_doubly_linked_list.sv
// Top level of the cursor linked list: command sequencer and node memories.
// Depends on cdll_pkg, cdll_ram and cursor_doubly_linked_list_defines.svh.
//
// A command is taken when start is high and busy is low. Every command runs through the
// sequence read, read, capture, write, write over node memories with one read and one
// write port each, and busy stays high through the whole sequence.
// The result is on the result ports for one cycle with done high and must be
// taken then; start may be raised in that same cycle. Clear runs through the same
// sequence, as the free stack is rebuilt through a low-water mark. length and
// cursor_valid always show the current list state.
`include "cursor_doubly_linked_list_defines.svh"

module cursor_doubly_linked_list #(
    parameter int POOL_SIZE  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cdll_pkg::MODE_W-1:0]       mode,
    input  logic signed [cdll_pkg::VAL_W-1:0] value,
    output logic                              busy,
    output logic                              done,
    output logic signed [cdll_pkg::VAL_W-1:0] read_value,
    output logic                              error,
    output logic                              cursor_valid,
    output logic [cdll_pkg::LEN_W-1:0]        length
);
    import cdll_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);
    localparam int PW = $clog2(POOL_SIZE + 1);
    localparam logic [PW-1:0] NULLP = PW'(POOL_SIZE);

    typedef enum logic [2:0] {S_IDLE, S_RA, S_RB, S_RC, S_W1, S_W2} state_t;

    state_t                        state_reg;
    logic [MODE_W-1:0]             mode_reg;
    logic [DATA_WIDTH-1:0]         val_reg;
    logic [PW-1:0]                 head_reg, tail_reg, cur_reg, fc_reg, lw_reg;
    logic [PW-1:0]                 nx_reg, pv_reg, nx2_reg, pv2_reg, n_reg;
    logic signed [DATA_WIDTH-1:0]  dat_reg;
    logic                          done_reg, err_reg;
    logic signed [VAL_W-1:0]       rv_reg;

    logic [PW-1:0]         head_next, tail_next, cur_next, fc_next, lw_next;
    logic                  err_next;
    logic signed [VAL_W-1:0] rv_next;

    logic [PW-1:0]         nx_q, pv_q;
    logic [DATA_WIDTH-1:0] dat_q;
    logic [IW-1:0]         stk_q;

    logic [PW-1:0]         ra1, ra2;
    logic [IW-1:0]         raddr;
    logic [PW-1:0]         pos, n_pop;

    logic                  nx_we, pv_we, d_we, s_we;
    logic [PW-1:0]         nx_wa, pv_wa, d_wa;
    logic [PW-1:0]         nx_wd, pv_wd;
    logic [DATA_WIDTH-1:0] d_wd;
    logic [IW-1:0]         s_wd;

    logic hv, cv, full, ok9, ok10;

    assign hv   = head_reg < NULLP;
    assign cv   = cur_reg < NULLP;
    assign full = fc_reg == '0;
    assign ok9  = cv && (cur_reg != tail_reg) && (nx_reg < NULLP);
    assign ok10 = cv && (cur_reg != head_reg) && (pv_reg < NULLP);

    assign pos   = fc_reg - 1'b1;
    assign n_pop = (pos < lw_reg) ? pos : PW'(stk_q);

    always_comb
    begin
        unique case (mode_reg)
            M_GET_FIRST, M_DEL_FIRST: ra1 = head_reg;
            M_GET_LAST, M_DEL_LAST:   ra1 = tail_reg;
            default:                  ra1 = cur_reg;
        endcase
        ra2   = (mode_reg == M_DEL_AFTER) ? nx_q : pv_q;
        raddr = (state_reg == S_RB) ? ra2[IW-1:0] : ra1[IW-1:0];
    end

    cdll_ram #(.DEPTH(POOL_SIZE), .WIDTH(PW), .AW(IW)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa[IW-1:0]), .wdata(nx_wd),
        .raddr(raddr), .rdata(nx_q)
    );
    cdll_ram #(.DEPTH(POOL_SIZE), .WIDTH(PW), .AW(IW)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa[IW-1:0]), .wdata(pv_wd),
        .raddr(raddr), .rdata(pv_q)
    );
    cdll_ram #(.DEPTH(POOL_SIZE), .WIDTH(DATA_WIDTH), .AW(IW)) u_data (
        .clk(clk), .we(d_we), .waddr(d_wa[IW-1:0]), .wdata(d_wd),
        .raddr(raddr), .rdata(dat_q)
    );
    cdll_ram #(.DEPTH(POOL_SIZE), .WIDTH(IW), .AW(IW)) u_free (
        .clk(clk), .we(s_we), .waddr(fc_reg[IW-1:0]), .wdata(s_wd),
        .raddr(pos[IW-1:0]), .rdata(stk_q)
    );

    // memory write ports
    always_comb
    begin
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        d_we  = 1'b0; d_wa  = '0; d_wd  = val_reg;
        s_we  = 1'b0; s_wd  = '0;
        if (state_reg == S_W1)
        begin
            unique case (mode_reg)
                M_INS_FIRST, M_INS_LAST:
                begin
                    if (!full)
                    begin
                        d_we  = 1'b1; d_wa = n_reg;
                        nx_we = 1'b1; nx_wa = n_reg;
                        nx_wd = (hv && mode_reg == M_INS_FIRST) ? head_reg : NULLP;
                        pv_we = 1'b1; pv_wa = n_reg;
                        pv_wd = (hv && mode_reg == M_INS_LAST) ? tail_reg : NULLP;
                    end
                end
                M_INS_AFTER, M_INS_BEFORE:
                begin
                    if (cv && !full)
                    begin
                        d_we  = 1'b1; d_wa = n_reg;
                        nx_we = 1'b1; nx_wa = n_reg;
                        pv_we = 1'b1; pv_wa = n_reg;
                        nx_wd = (mode_reg == M_INS_AFTER) ? nx_reg : cur_reg;
                        pv_wd = (mode_reg == M_INS_AFTER) ? cur_reg : pv_reg;
                    end
                end
                M_DEL_FIRST:
                begin
                    if (hv)
                    begin
                        s_we = 1'b1; s_wd = head_reg[IW-1:0];
                        if (head_reg != tail_reg && nx_reg < NULLP)
                        begin
                            pv_we = 1'b1; pv_wa = nx_reg; pv_wd = NULLP;
                        end
                    end
                end
                M_DEL_LAST:
                begin
                    if (tail_reg < NULLP)
                    begin
                        s_we = 1'b1; s_wd = tail_reg[IW-1:0];
                        if (tail_reg != head_reg && pv_reg < NULLP)
                        begin
                            nx_we = 1'b1; nx_wa = pv_reg; nx_wd = NULLP;
                        end
                    end
                end
                M_DEL_AFTER:
                begin
                    if (ok9)
                    begin
                        s_we  = 1'b1; s_wd = nx_reg[IW-1:0];
                        nx_we = 1'b1; nx_wa = cur_reg; nx_wd = nx2_reg;
                        if (nx_reg != tail_reg && nx2_reg < NULLP)
                        begin
                            pv_we = 1'b1; pv_wa = nx2_reg; pv_wd = cur_reg;
                        end
                    end
                end
                M_DEL_BEFORE:
                begin
                    if (ok10)
                    begin
                        s_we  = 1'b1; s_wd = pv_reg[IW-1:0];
                        pv_we = 1'b1; pv_wa = cur_reg; pv_wd = pv2_reg;
                        if (pv_reg != head_reg && pv2_reg < NULLP)
                        begin
                            nx_we = 1'b1; nx_wa = pv2_reg; nx_wd = cur_reg;
                        end
                    end
                end
                M_SET:
                begin
                    if (cv)
                    begin
                        d_we = 1'b1; d_wa = cur_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_W2)
        begin
            unique case (mode_reg)
                M_INS_FIRST:
                begin
                    if (!full && hv)
                    begin
                        pv_we = 1'b1; pv_wa = head_reg; pv_wd = n_reg;
                    end
                end
                M_INS_LAST:
                begin
                    if (!full && hv)
                    begin
                        nx_we = 1'b1; nx_wa = tail_reg; nx_wd = n_reg;
                    end
                end
                M_INS_AFTER:
                begin
                    if (cv && !full)
                    begin
                        nx_we = 1'b1; nx_wa = cur_reg; nx_wd = n_reg;
                        if (nx_reg < NULLP)
                        begin
                            pv_we = 1'b1; pv_wa = nx_reg; pv_wd = n_reg;
                        end
                    end
                end
                M_INS_BEFORE:
                begin
                    if (cv && !full)
                    begin
                        pv_we = 1'b1; pv_wa = cur_reg; pv_wd = n_reg;
                        if (pv_reg < NULLP)
                        begin
                            nx_we = 1'b1; nx_wa = pv_reg; nx_wd = n_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // list state after the command
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next  = cur_reg;
        fc_next   = fc_reg;
        lw_next   = lw_reg;
        err_next  = 1'b0;
        rv_next   = '0;
        unique case (mode_reg)
            M_CLEAR:
            begin
                head_next = NULLP;
                tail_next = NULLP;
                cur_next  = NULLP;
                fc_next   = NULLP;
                lw_next   = NULLP;
            end
            M_INS_FIRST, M_INS_LAST:
            begin
                if (full)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    fc_next = pos;
                    lw_next = (pos < lw_reg) ? pos : lw_reg;
                    if (!hv)
                    begin
                        head_next = n_reg;
                        tail_next = n_reg;
                    end
                    else if (mode_reg == M_INS_FIRST)
                    begin
                        head_next = n_reg;
                    end
                    else
                    begin
                        tail_next = n_reg;
                    end
                end
            end
            M_FIRST: cur_next = head_reg;
            M_LAST:  cur_next = tail_reg;
            M_GET_FIRST, M_GET_LAST, M_GET:
            begin
                if (ra1 < NULLP)
                begin
                    rv_next = VAL_W'(dat_reg);
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            M_DEL_FIRST:
            begin
                if (hv)
                begin
                    head_next = (head_reg == tail_reg) ? NULLP : nx_reg;
                    tail_next = (head_reg == tail_reg) ? NULLP : tail_reg;
                    fc_next   = fc_reg + 1'b1;
                    if (cur_reg == head_reg)
                    begin
                        cur_next = NULLP;
                    end
                end
            end
            M_DEL_LAST:
            begin
                if (tail_reg < NULLP)
                begin
                    tail_next = (head_reg == tail_reg) ? NULLP : pv_reg;
                    head_next = (head_reg == tail_reg) ? NULLP : head_reg;
                    fc_next   = fc_reg + 1'b1;
                    if (cur_reg == tail_reg)
                    begin
                        cur_next = NULLP;
                    end
                end
            end
            M_DEL_AFTER:
            begin
                if (ok9)
                begin
                    fc_next = fc_reg + 1'b1;
                    if (nx_reg == tail_reg)
                    begin
                        tail_next = cur_reg;
                    end
                end
            end
            M_DEL_BEFORE:
            begin
                if (ok10)
                begin
                    fc_next = fc_reg + 1'b1;
                    if (pv_reg == head_reg)
                    begin
                        head_next = cur_reg;
                    end
                end
            end
            M_INS_AFTER, M_INS_BEFORE:
            begin
                if (cv && full)
                begin
                    err_next = 1'b1;
                end
                else if (cv)
                begin
                    fc_next = pos;
                    lw_next = (pos < lw_reg) ? pos : lw_reg;
                    if (mode_reg == M_INS_AFTER && !(nx_reg < NULLP))
                    begin
                        tail_next = n_reg;
                    end
                    if (mode_reg == M_INS_BEFORE && !(pv_reg < NULLP))
                    begin
                        head_next = n_reg;
                    end
                end
            end
            M_NEXT:
            begin
                if (cv)
                begin
                    cur_next = nx_reg;
                end
            end
            M_PREV:
            begin
                if (cv)
                begin
                    cur_next = pv_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (!(cur_next < NULLP))
        begin
            cur_next = NULLP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= NULLP;
            tail_reg  <= NULLP;
            cur_reg   <= NULLP;
            fc_reg    <= NULLP;
            lw_reg    <= NULLP;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
            rv_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_RA;
                    end
                end
                S_RA: state_reg <= S_RB;
                S_RB: state_reg <= S_RC;
                S_RC: state_reg <= S_W1;
                S_W1: state_reg <= S_W2;
                S_W2:
                begin
                    state_reg <= S_IDLE;
                    head_reg  <= head_next;
                    tail_reg  <= tail_next;
                    cur_reg   <= cur_next;
                    fc_reg    <= fc_next;
                    lw_reg    <= lw_next;
                    err_reg   <= err_next;
                    rv_reg    <= rv_next;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // command payload and read captures
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            mode_reg <= mode;
            val_reg  <= DATA_WIDTH'(value);
        end
        if (state_reg == S_RB)
        begin
            nx_reg  <= nx_q;
            pv_reg  <= pv_q;
            dat_reg <= dat_q;
            n_reg   <= n_pop;
        end
        if (state_reg == S_RC)
        begin
            nx2_reg <= nx_q;
            pv2_reg <= pv_q;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign read_value   = rv_reg;
    assign error        = err_reg;
    assign cursor_valid = cur_reg < NULLP;
    assign length       = LEN_W'(NULLP - fc_reg);

    `CDLL_CHECK(a_done_idle, !(done && busy), "result strobe while a command is in flight")
    `CDLL_CHECK(a_fc_range, fc_reg <= NULLP, "free count above pool size")
    `CDLL_CHECK(a_lw_below_fc, lw_reg <= fc_reg, "free stack low-water mark above free count")
    `CDLL_CHECK_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted command not started")
    `CDLL_CHECK_NEXT(a_w2_done, state_reg == S_W2, done, "command finished without result")

endmodule

// File: src/cdll_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module cdll_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: verif/list_checker.sv
// Checker for the cursor linked list: predicts each command's result and compares it.
// Depends on cdll_pkg; watches the command and result ports of the block.
`timescale 1ns / 1ps

module list_checker
    import cdll_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [VAL_W-1:0]  value,
    input  logic                     done,
    input  logic signed [VAL_W-1:0]  read_value,
    input  logic                     error,
    input  logic                     cursor_valid,
    input  logic [LEN_W-1:0]         length,
    output int                       fail_count,
    output int                       pending,
    output int                       checked,
    output int                       errors_seen
);

    localparam int POOL = 64;
    localparam logic [6:0] NULL_IDX = 7'd64;

    typedef struct packed {
        logic signed [VAL_W-1:0] rd;
        logic                    err;
        logic                    cv;
        logic [LEN_W-1:0]        len;
    } outcome_t;

    logic signed [VAL_W-1:0] data_mem [POOL];
    logic [6:0]              next_mem [POOL];
    logic [6:0]              prev_mem [POOL];
    logic [6:0]              free_stk [POOL];
    int                      free_cnt;
    logic [6:0]              head, tail, cur;
    outcome_t                outcome_q [$];

    function automatic bit is_node(logic [6:0] p);
        return p < POOL;
    endfunction

    task automatic rebuild_pool();
        for (int i = 0; i < POOL; i++)
            free_stk[i] = 7'(i);
        free_cnt = POOL;
        head = NULL_IDX;
        tail = NULL_IDX;
        cur  = NULL_IDX;
    endtask

    task automatic release_node(logic [6:0] p);
        if (is_node(p) && free_cnt < POOL)
        begin
            free_stk[free_cnt] = p;
            free_cnt++;
            if (cur == p)
                cur = NULL_IDX;
        end
    endtask

    task automatic list_step(input logic [MODE_W-1:0] m, input logic signed [VAL_W-1:0] v,
                             output outcome_t o);
        logic [6:0]              n, a, b;
        logic signed [VAL_W-1:0] rd;
        logic                    err;
        rd  = '0;
        err = 1'b0;
        case (m)
            M_CLEAR: rebuild_pool();
            M_INS_FIRST, M_INS_LAST:
            begin
                if (free_cnt == 0)
                    err = 1'b1;
                else
                begin
                    free_cnt--;
                    n = free_stk[free_cnt];
                    data_mem[n] = v;
                    if (!is_node(head))
                    begin
                        next_mem[n] = NULL_IDX;
                        prev_mem[n] = NULL_IDX;
                        head = n;
                        tail = n;
                    end
                    else if (m == M_INS_FIRST)
                    begin
                        next_mem[n] = head;
                        prev_mem[n] = NULL_IDX;
                        prev_mem[head] = n;
                        head = n;
                    end
                    else
                    begin
                        next_mem[n] = NULL_IDX;
                        prev_mem[n] = tail;
                        next_mem[tail] = n;
                        tail = n;
                    end
                end
            end
            M_FIRST: cur = head;
            M_LAST:  cur = tail;
            M_GET_FIRST, M_GET_LAST, M_GET:
            begin
                a = (m == M_GET_FIRST) ? head : (m == M_GET_LAST) ? tail : cur;
                if (!is_node(a))
                    err = 1'b1;
                else
                    rd = data_mem[a];
            end
            M_DEL_FIRST:
            begin
                a = head;
                if (is_node(a))
                begin
                    if (a == tail)
                    begin
                        head = NULL_IDX;
                        tail = NULL_IDX;
                    end
                    else
                    begin
                        head = next_mem[a];
                        if (is_node(head))
                            prev_mem[head] = NULL_IDX;
                    end
                    release_node(a);
                end
            end
            M_DEL_LAST:
            begin
                a = tail;
                if (is_node(a))
                begin
                    if (a == head)
                    begin
                        head = NULL_IDX;
                        tail = NULL_IDX;
                    end
                    else
                    begin
                        tail = prev_mem[a];
                        if (is_node(tail))
                            next_mem[tail] = NULL_IDX;
                    end
                    release_node(a);
                end
            end
            M_DEL_AFTER:
            begin
                if (is_node(cur) && cur != tail && is_node(next_mem[cur]))
                begin
                    a = next_mem[cur];
                    b = next_mem[a];
                    next_mem[cur] = b;
                    if (a == tail)
                        tail = cur;
                    else if (is_node(b))
                        prev_mem[b] = cur;
                    release_node(a);
                end
            end
            M_DEL_BEFORE:
            begin
                if (is_node(cur) && cur != head && is_node(prev_mem[cur]))
                begin
                    a = prev_mem[cur];
                    b = prev_mem[a];
                    prev_mem[cur] = b;
                    if (a == head)
                        head = cur;
                    else if (is_node(b))
                        next_mem[b] = cur;
                    release_node(a);
                end
            end
            M_INS_AFTER, M_INS_BEFORE:
            begin
                if (is_node(cur))
                begin
                    if (free_cnt == 0)
                        err = 1'b1;
                    else
                    begin
                        free_cnt--;
                        n = free_stk[free_cnt];
                        data_mem[n] = v;
                        if (m == M_INS_AFTER)
                        begin
                            b = next_mem[cur];
                            prev_mem[n] = cur;
                            next_mem[n] = b;
                            if (is_node(b))
                                prev_mem[b] = n;
                            else
                                tail = n;
                            next_mem[cur] = n;
                        end
                        else
                        begin
                            b = prev_mem[cur];
                            next_mem[n] = cur;
                            prev_mem[n] = b;
                            if (is_node(b))
                                next_mem[b] = n;
                            else
                                head = n;
                            prev_mem[cur] = n;
                        end
                    end
                end
            end
            M_SET:
            begin
                if (is_node(cur))
                    data_mem[cur] = v;
            end
            M_NEXT:
            begin
                if (is_node(cur))
                    cur = next_mem[cur];
            end
            M_PREV:
            begin
                if (is_node(cur))
                    cur = prev_mem[cur];
            end
            default: ;
        endcase
        if (!is_node(cur))
            cur = NULL_IDX;
        o.rd  = rd;
        o.err = err;
        o.cv  = is_node(cur);
        o.len = LEN_W'(POOL - free_cnt);
    endtask

    initial
    begin
        rebuild_pool();
        fail_count  = 0;
        checked     = 0;
        errors_seen = 0;
    end

    assign pending = outcome_q.size();

    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n)
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected transaction result", $time);
                end
                else
                begin
                    o = outcome_q.pop_front();
                    checked++;
                    if (o.err)
                        errors_seen++;
                    if (read_value !== o.rd || error !== o.err ||
                        cursor_valid !== o.cv || length !== o.len)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp rd=%0d err=%0b cv=%0b len=%0d",
                                     $time, o.rd, o.err, o.cv, o.len);
                            $display("    got rd=%0d err=%0b cv=%0b len=%0d",
                                     read_value, error, cursor_valid, length);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                list_step(mode, value, o);
                outcome_q.push_back(o);
            end
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the cursor linked list testbench: clock, reset, command stimulus and verdict.
// Depends on cdll_pkg, list_checker and the cursor_doubly_linked_list block.
`timescale 1ns / 1ps

module testbench;
    import cdll_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    logic                    busy, done, error, cursor_valid;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    int                      fail_count, pending, checked, errors_seen;
    int                      idle_cycles;
    int                      sent;
    int                      full_hits;

    cursor_doubly_linked_list uut (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode), .value(value),
        .busy(busy), .done(done), .read_value(read_value), .error(error),
        .cursor_valid(cursor_valid), .length(length)
    );

    list_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .value(value), .done(done), .read_value(read_value), .error(error),
        .cursor_valid(cursor_valid), .length(length), .fail_count(fail_count),
        .pending(pending), .checked(checked), .errors_seen(errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (done && length == 7'd64)
            full_hits <= full_hits + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue(input logic [MODE_W-1:0] m, input logic signed [VAL_W-1:0] v);
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic idle_gap(input bit bursty);
        int gap;
        if (bursty)
            gap = 0;
        else if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(10, 60);
        else
            gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // weights: ins, del, move, access; the rest is split between clear and unused mode codes
    function automatic logic [MODE_W-1:0] pick_mode(int w_ins, int w_del, int w_mov,
                                                    int w_acc);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins)
            return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? M_INS_FIRST : M_INS_LAST)
                                        : ($urandom_range(0, 1) ? M_INS_AFTER : M_INS_BEFORE);
        r -= w_ins;
        if (r < w_del)
            case ($urandom_range(0, 3))
                0: return M_DEL_FIRST;
                1: return M_DEL_LAST;
                2: return M_DEL_AFTER;
                default: return M_DEL_BEFORE;
            endcase
        r -= w_del;
        if (r < w_mov)
            case ($urandom_range(0, 5))
                0: return M_FIRST;
                1: return M_LAST;
                2, 3: return M_NEXT;
                default: return M_PREV;
            endcase
        r -= w_mov;
        if (r < w_acc)
            case ($urandom_range(0, 3))
                0: return M_GET_FIRST;
                1: return M_GET_LAST;
                2: return M_GET;
                default: return M_SET;
            endcase
        if ($urandom_range(0, 1))
            return M_CLEAR;
        return MODE_W'(M_PREV + 1 + $urandom_range(0, 14));
    endfunction

    task automatic random_phase(int count, int w_ins, int w_del, int w_mov, int w_acc);
        bit bursty;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                bursty = $urandom_range(0, 2) == 0;
            issue(pick_mode(w_ins, w_del, w_mov, w_acc), pick_value());
            idle_gap(bursty);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = M_CLEAR;
        value       = '0;
        sent        = 0;
        full_hits   = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // on empty list reads fail, others do nothing; then insert, move, read and delete
        issue(M_GET_FIRST, '0);
        issue(M_GET_LAST, '0);
        issue(M_GET, '0);
        issue(M_DEL_FIRST, '0);
        issue(M_DEL_LAST, '0);
        issue(M_INS_AFTER, 32'sd5);
        issue(M_SET, 32'sd9);
        issue(M_NEXT, '0);
        issue(M_PREV, '0);
        issue(MODE_W'(M_PREV + 1), 32'sd1);
        issue({MODE_W{1'b1}}, -32'sd1);
        issue(M_INS_FIRST, 32'sh8000_0000);
        issue(M_INS_LAST, 32'sh7FFF_FFFF);
        issue(M_FIRST, '0);
        issue(M_INS_BEFORE, -32'sd1);
        issue(M_INS_AFTER, 32'sh5555_AAAA);
        issue(M_GET, '0);
        issue(M_DEL_BEFORE, '0);
        issue(M_DEL_AFTER, '0);
        issue(M_LAST, '0);
        issue(M_NEXT, '0);
        issue(M_GET_FIRST, '0);
        issue(M_GET_LAST, '0);
        issue(M_DEL_FIRST, '0);
        issue(M_CLEAR, '0);
        drain();

        random_phase(150, 35, 20, 25, 17);
        drain();
        // fill the pool past its limit
        for (int i = 0; i < 70; i++)
            issue($urandom_range(0, 1) ? M_INS_FIRST : M_INS_LAST, pick_value());
        random_phase(100, 70, 5, 13, 12);
        drain();
        random_phase(130, 15, 45, 22, 16);
        drain();

        repeat (20) @(posedge clk);
        $display("Ran %0d commands, %0d results checked, %0d with error flag, %0d at full pool.",
                 sent, checked, errors_seen, full_hits);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
